// ----- rtl/core/tor_pkg.sv -----
// Package for the tube outline rasterizer: states, response struct and constants.
package tor_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_POINT = 2'd1,
        CMD_END   = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SHOW   = 2'd2;

    localparam logic [7:0] PIX_ALPHA = 8'd178;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CLEAR,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_D2X,
        ST_D2Y,
        ST_D2S,
        ST_AA,
        ST_BB,
        ST_SQ_WAIT,
        ST_NCNT,
        ST_UX_START,
        ST_UX_WAIT,
        ST_UY_WAIT,
        ST_K,
        ST_KK,
        ST_L_WAIT,
        ST_MX,
        ST_MY,
        ST_MR,
        ST_MRR,
        ST_MOX,
        ST_MOY,
        ST_MOZ,
        ST_PLOT_P,
        ST_PLOT_A,
        ST_PLOT_B,
        ST_UPDATE,
        ST_FINISH
    } tor_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT
    } ds_state_t;

    typedef struct packed {
        logic        done;
        logic [15:0] root;
    } ds_resp_t;

endpackage

// ----- rtl/core/tor_divsqrt.sv -----
// Iterative unit: integer square root of floor(num / den), one bit per cycle.
module tor_divsqrt
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        num,
    input  logic [31:0]        den,
    output tor_pkg::ds_resp_t  resp
);

    tor_pkg::ds_state_t st_reg, st_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] sh_reg, sh_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] den_reg, den_next;
    logic [31:0] root_reg, root_next;

    logic [32:0] tmp;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] bitv;
    logic [32:0] trial;
    logic        sge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= tor_pkg::DS_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        tmp   = {rem_reg, sh_reg[31]};
        diff  = tmp - {1'b0, den_reg};
        ge    = tmp >= {1'b0, den_reg};
        bitv  = 32'd1 << {cnt_reg[3:0], 1'b0};
        trial = {1'b0, root_reg} + {1'b0, bitv};
        sge   = {1'b0, acc_reg} >= trial;

        st_next   = st_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        acc_next  = acc_reg;
        den_next  = den_reg;
        root_next = root_reg;

        case (st_reg)
            tor_pkg::DS_IDLE:
            begin
                if (start)
                begin
                    rem_next = num[63:32];
                    sh_next  = num[31:0];
                    den_next = den;
                    acc_next = '0;
                    cnt_next = 5'd31;
                    st_next  = tor_pkg::DS_DIV;
                end
            end
            tor_pkg::DS_DIV:
            begin
                rem_next = ge ? diff[31:0] : tmp[31:0];
                sh_next  = {sh_reg[30:0], 1'b0};
                acc_next = {acc_reg[30:0], ge};
                if (cnt_reg == 5'd0)
                begin
                    cnt_next  = 5'd15;
                    root_next = '0;
                    st_next   = tor_pkg::DS_SQRT;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            tor_pkg::DS_SQRT:
            begin
                if (sge)
                begin
                    acc_next  = acc_reg - trial[31:0];
                    root_next = (root_reg >> 1) + bitv;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                if (cnt_reg == 5'd0)
                begin
                    done_next = 1'b1;
                    st_next   = tor_pkg::DS_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            default:
            begin
                st_next = tor_pkg::DS_IDLE;
            end
        endcase
    end

    assign resp.done = done_reg;
    assign resp.root = root_reg[15:0];

endmodule

// ----- rtl/core/tube_outline_rasterizer_core.sv -----
// Tube outline rasterizer: draws tube segments and edge lines into an RGBA frame store.
//
// Input channel (in_valid/in_stall) takes one command per transaction: clear the
// store, add a tube point, end the tube, or read one pixel. Each command gives one
// result transaction on the output channel (out_valid/out_stall): the pixel word for
// a read, zero otherwise, with done_res set. One command is worked on at a time.
// A segment point runs a setup of squares and roots, then plots ceil(length) samples,
// each with its edge lines when they are on; both share the divide/square-root unit
// and the single multiplier that also forms the read and plot store addresses.
// After reset the block sweeps the whole store to zero with in_stall high;
// configuration writes are taken at any time.
// A waiting result sits in the output register; the next command is accepted
// meanwhile, and its result waits until the receiver drops out_stall.
module tube_outline_rasterizer_core
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [8:0]         pos_x,
    input  logic [8:0]         pos_y,
    input  logic [15:0]        radius,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        pixel_rgba,
    output logic               done_res,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    tor_pkg::tor_state_t state_reg, state_next;

    logic [1:0]  cmd_reg;
    logic [8:0]  px_reg, py_reg;
    logic [15:0] rad_reg;
    logic [23:0] col_reg;
    logic [15:0] nx_reg, ny_reg;

    logic        have_point_reg, have_point_next;
    logic        have_prev_reg, have_prev_next;
    logic [8:0]  last_x_reg, last_x_next, last_y_reg, last_y_next;
    logic [15:0] last_rad_reg, last_rad_next;
    logic [23:0] last_col_reg, last_col_next;
    logic [15:0] last_nx_reg, last_nx_next, last_ny_reg, last_ny_next;
    logic [8:0]  early_x_reg, early_x_next, early_y_reg, early_y_next;

    logic [9:0]  width_reg, height_reg;
    logic        show_reg;
    logic [9:0]  eff_w, eff_h;

    logic [9:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic [16:0] dr_reg, dr_next;
    logic [19:0] d2_reg, d2_next;
    logic [15:0] s_reg, s_next;
    logic [10:0] n_reg, n_next, k_reg, k_next;
    logic [16:0] a_reg, a_next, b_reg, b_next;
    logic [30:0] aa_reg, aa_next, bb_reg, bb_next;
    logic [31:0] n2_reg, n2_next;
    logic [15:0] ux_reg, ux_next, uy_reg, uy_next;
    logic [15:0] l_reg, l_next;
    logic [35:0] xc_reg, xc_next, yc_reg, yc_next;
    logic [15:0] r_reg, r_next;
    logic [35:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [1:0]  pidx_reg, pidx_next;
    logic [35:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic [9:0]  xi_reg, xi_next;
    logic        pok_reg, pok_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_cmd_reg, clr_cmd_next;
    logic [31:0] pix_reg, pix_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pix_reg, out_pix_next;

    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod_reg;

    logic              ds_start;
    logic [63:0]       ds_num;
    logic [31:0]       ds_den;
    tor_pkg::ds_resp_t ds_resp;

    logic [31:0] mem [DEPTH];
    logic [31:0] mem_q;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata;

    logic [9:0]  tx, ty;
    logic [8:0]  ex, ey;
    logic [33:0] rsum;
    logic [31:0] word;

    tor_divsqrt u_divsqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ds_start),
        .num   (ds_num),
        .den   (ds_den),
        .resp  (ds_resp)
    );

    assign eff_w = (32'(width_reg) > MAX_WIDTH) ? 10'(MAX_WIDTH) : width_reg;
    assign eff_h = (32'(height_reg) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : height_reg;
    assign word  = {tor_pkg::PIX_ALPHA, last_col_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tor_pkg::ST_CLEAR;
            have_point_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
            clr_cnt_reg    <= '0;
            clr_cmd_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
            width_reg      <= 10'd512;
            height_reg     <= 10'd512;
            show_reg       <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            have_point_reg <= have_point_next;
            have_prev_reg  <= have_prev_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_cmd_reg    <= clr_cmd_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tor_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    tor_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    tor_pkg::CFG_SHOW:   show_reg   <= cfg_data[0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= cmd;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            rad_reg <= radius;
            col_reg <= {blue, green, red};
            nx_reg  <= normal_x;
            ny_reg  <= normal_y;
        end
        last_x_reg   <= last_x_next;
        last_y_reg   <= last_y_next;
        last_rad_reg <= last_rad_next;
        last_col_reg <= last_col_next;
        last_nx_reg  <= last_nx_next;
        last_ny_reg  <= last_ny_next;
        early_x_reg  <= early_x_next;
        early_y_reg  <= early_y_next;
        dx_reg   <= dx_next;
        dy_reg   <= dy_next;
        dr_reg   <= dr_next;
        d2_reg   <= d2_next;
        s_reg    <= s_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        aa_reg   <= aa_next;
        bb_reg   <= bb_next;
        n2_reg   <= n2_next;
        ux_reg   <= ux_next;
        uy_reg   <= uy_next;
        l_reg    <= l_next;
        xc_reg   <= xc_next;
        yc_reg   <= yc_next;
        r_reg    <= r_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        pidx_reg <= pidx_next;
        pt_x_reg <= pt_x_next;
        pt_y_reg <= pt_y_next;
        xi_reg   <= xi_next;
        pok_reg  <= pok_next;
        pix_reg  <= pix_next;
        out_pix_reg <= out_pix_next;
        prod_reg <= mul_a * mul_b;
    end

    always_comb
    begin
        ex   = have_prev_reg ? early_x_reg : last_x_reg;
        ey   = have_prev_reg ? early_y_reg : last_y_reg;
        tx   = {1'b0, px_reg} - {1'b0, ex};
        ty   = {1'b0, py_reg} - {1'b0, ey};
        rsum = {2'b00, last_rad_reg, 16'd0} + prod_reg;

        state_next      = state_reg;
        have_point_next = have_point_reg;
        have_prev_next  = have_prev_reg;
        last_x_next     = last_x_reg;
        last_y_next     = last_y_reg;
        last_rad_next   = last_rad_reg;
        last_col_next   = last_col_reg;
        last_nx_next    = last_nx_reg;
        last_ny_next    = last_ny_reg;
        early_x_next    = early_x_reg;
        early_y_next    = early_y_reg;
        dx_next   = dx_reg;
        dy_next   = dy_reg;
        dr_next   = dr_reg;
        d2_next   = d2_reg;
        s_next    = s_reg;
        n_next    = n_reg;
        k_next    = k_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        aa_next   = aa_reg;
        bb_next   = bb_reg;
        n2_next   = n2_reg;
        ux_next   = ux_reg;
        uy_next   = uy_reg;
        l_next    = l_reg;
        xc_next   = xc_reg;
        yc_next   = yc_reg;
        r_next    = r_reg;
        ox_next   = ox_reg;
        oy_next   = oy_reg;
        pidx_next = pidx_reg;
        pt_x_next = pt_x_reg;
        pt_y_next = pt_y_reg;
        xi_next   = xi_reg;
        pok_next  = pok_reg;
        clr_cnt_next = clr_cnt_reg;
        clr_cmd_next = clr_cmd_reg;
        pix_next     = pix_reg;
        out_pix_next = out_pix_reg;
        out_valid_next = out_valid_reg && out_stall;

        mul_a     = '0;
        mul_b     = '0;
        ds_start  = 1'b0;
        ds_num    = '0;
        ds_den    = '0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = '0;

        case (state_reg)
            tor_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = tor_pkg::ST_DISPATCH;
                end
            end
            tor_pkg::ST_DISPATCH:
            begin
                pix_next = '0;
                case (cmd_reg)
                    tor_pkg::CMD_CLEAR:
                    begin
                        clr_cnt_next = '0;
                        clr_cmd_next = 1'b1;
                        state_next   = tor_pkg::ST_CLEAR;
                    end
                    tor_pkg::CMD_POINT:
                    begin
                        dx_next = {1'b0, px_reg} - {1'b0, last_x_reg};
                        dy_next = {1'b0, py_reg} - {1'b0, last_y_reg};
                        dr_next = {1'b0, rad_reg} - {1'b0, last_rad_reg};
                        if (last_nx_reg == 16'd0 && last_ny_reg == 16'd0)
                        begin
                            a_next = {{7{ty[9]}}, ty};
                            b_next = 17'd0 - {{7{tx[9]}}, tx};
                        end
                        else
                        begin
                            a_next = {last_nx_reg[15], last_nx_reg};
                            b_next = {last_ny_reg[15], last_ny_reg};
                        end
                        state_next = have_point_reg ? tor_pkg::ST_D2X : tor_pkg::ST_UPDATE;
                    end
                    tor_pkg::CMD_END:
                    begin
                        have_point_next = 1'b0;
                        have_prev_next  = 1'b0;
                        state_next      = tor_pkg::ST_FINISH;
                    end
                    default:
                    begin
                        mul_a = {8'd0, py_reg};
                        mul_b = {7'd0, eff_w};
                        if ({1'b0, px_reg} < eff_w && {1'b0, py_reg} < eff_h)
                        begin
                            state_next = tor_pkg::ST_RD_ADDR;
                        end
                        else
                        begin
                            state_next = tor_pkg::ST_FINISH;
                        end
                    end
                endcase
            end
            tor_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                if (32'(clr_cnt_reg) == DEPTH - 1)
                begin
                    clr_cmd_next = 1'b0;
                    state_next   = clr_cmd_reg ? tor_pkg::ST_FINISH : tor_pkg::ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            tor_pkg::ST_RD_ADDR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = prod_reg[ADDR_W-1:0] + ADDR_W'(px_reg);
                state_next = tor_pkg::ST_RD_DATA;
            end
            tor_pkg::ST_RD_DATA:
            begin
                pix_next   = mem_q;
                state_next = tor_pkg::ST_FINISH;
            end
            tor_pkg::ST_D2X:
            begin
                mul_a      = {{7{dx_reg[9]}}, dx_reg};
                mul_b      = {{7{dx_reg[9]}}, dx_reg};
                state_next = tor_pkg::ST_D2Y;
            end
            tor_pkg::ST_D2Y:
            begin
                d2_next    = prod_reg[19:0];
                mul_a      = {{7{dy_reg[9]}}, dy_reg};
                mul_b      = {{7{dy_reg[9]}}, dy_reg};
                state_next = tor_pkg::ST_D2S;
            end
            tor_pkg::ST_D2S:
            begin
                d2_next    = d2_reg + prod_reg[19:0];
                mul_a      = a_reg;
                mul_b      = a_reg;
                state_next = tor_pkg::ST_AA;
            end
            tor_pkg::ST_AA:
            begin
                aa_next    = prod_reg[30:0];
                mul_a      = b_reg;
                mul_b      = b_reg;
                ds_start   = 1'b1;
                ds_num     = {44'd0, d2_reg};
                ds_den     = 32'd1;
                state_next = tor_pkg::ST_BB;
            end
            tor_pkg::ST_BB:
            begin
                bb_next    = prod_reg[30:0];
                state_next = tor_pkg::ST_SQ_WAIT;
            end
            tor_pkg::ST_SQ_WAIT:
            begin
                mul_a = {1'b0, ds_resp.root};
                mul_b = {1'b0, ds_resp.root};
                if (ds_resp.done)
                begin
                    s_next     = ds_resp.root;
                    state_next = tor_pkg::ST_NCNT;
                end
            end
            tor_pkg::ST_NCNT:
            begin
                // sample count is ceil of the length, at least one
                if (d2_reg == 20'd0)
                begin
                    n_next = 11'd1;
                end
                else if (prod_reg == {14'd0, d2_reg})
                begin
                    n_next = s_reg[10:0];
                end
                else
                begin
                    n_next = s_reg[10:0] + 11'd1;
                end
                k_next     = '0;
                n2_next    = {1'b0, aa_reg} + {1'b0, bb_reg};
                state_next = tor_pkg::ST_UX_START;
            end
            tor_pkg::ST_UX_START:
            begin
                if (n2_reg == 32'd0)
                begin
                    ux_next    = '0;
                    uy_next    = '0;
                    state_next = tor_pkg::ST_K;
                end
                else
                begin
                    ds_start   = 1'b1;
                    ds_num     = {5'd0, aa_reg, 28'd0};
                    ds_den     = n2_reg;
                    state_next = tor_pkg::ST_UX_WAIT;
                end
            end
            tor_pkg::ST_UX_WAIT:
            begin
                if (ds_resp.done)
                begin
                    ux_next    = a_reg[16] ? (16'd0 - ds_resp.root) : ds_resp.root;
                    ds_start   = 1'b1;
                    ds_num     = {5'd0, bb_reg, 28'd0};
                    ds_den     = n2_reg;
                    state_next = tor_pkg::ST_UY_WAIT;
                end
            end
            tor_pkg::ST_UY_WAIT:
            begin
                if (ds_resp.done)
                begin
                    uy_next    = b_reg[16] ? (16'd0 - ds_resp.root) : ds_resp.root;
                    state_next = tor_pkg::ST_K;
                end
            end
            tor_pkg::ST_K:
            begin
                if (d2_reg == 20'd0)
                begin
                    l_next     = '0;
                    state_next = tor_pkg::ST_MX;
                end
                else
                begin
                    mul_a      = {6'd0, k_reg};
                    mul_b      = {6'd0, k_reg};
                    state_next = tor_pkg::ST_KK;
                end
            end
            tor_pkg::ST_KK:
            begin
                // l = isqrt(k*k*2^32 / d2)
                ds_start   = 1'b1;
                ds_num     = {12'd0, prod_reg[19:0], 32'd0};
                ds_den     = {12'd0, d2_reg};
                state_next = tor_pkg::ST_L_WAIT;
            end
            tor_pkg::ST_L_WAIT:
            begin
                if (ds_resp.done)
                begin
                    l_next     = ds_resp.root;
                    state_next = tor_pkg::ST_MX;
                end
            end
            tor_pkg::ST_MX:
            begin
                mul_a      = {1'b0, l_reg};
                mul_b      = {{7{dx_reg[9]}}, dx_reg};
                state_next = tor_pkg::ST_MY;
            end
            tor_pkg::ST_MY:
            begin
                xc_next    = {5'd0, last_x_reg, 22'd0} + {prod_reg[29:0], 6'd0};
                mul_a      = {1'b0, l_reg};
                mul_b      = {{7{dy_reg[9]}}, dy_reg};
                state_next = tor_pkg::ST_MR;
            end
            tor_pkg::ST_MR:
            begin
                yc_next    = {5'd0, last_y_reg, 22'd0} + {prod_reg[29:0], 6'd0};
                mul_a      = {1'b0, l_reg};
                mul_b      = dr_reg;
                pidx_next  = '0;
                state_next = show_reg ? tor_pkg::ST_MRR : tor_pkg::ST_PLOT_P;
            end
            tor_pkg::ST_MRR:
            begin
                r_next     = rsum[31:16];
                state_next = tor_pkg::ST_MOX;
            end
            tor_pkg::ST_MOX:
            begin
                mul_a      = {1'b0, r_reg};
                mul_b      = {ux_reg[15], ux_reg};
                state_next = tor_pkg::ST_MOY;
            end
            tor_pkg::ST_MOY:
            begin
                ox_next    = {{2{prod_reg[33]}}, prod_reg};
                mul_a      = {1'b0, r_reg};
                mul_b      = {uy_reg[15], uy_reg};
                state_next = tor_pkg::ST_MOZ;
            end
            tor_pkg::ST_MOZ:
            begin
                oy_next    = {{2{prod_reg[33]}}, prod_reg};
                state_next = tor_pkg::ST_PLOT_P;
            end
            tor_pkg::ST_PLOT_P:
            begin
                // centre point, then the plus edge, then the minus edge
                case (pidx_reg)
                    2'd1:
                    begin
                        pt_x_next = xc_reg + ox_reg;
                        pt_y_next = yc_reg + oy_reg;
                    end
                    2'd2:
                    begin
                        pt_x_next = xc_reg - ox_reg;
                        pt_y_next = yc_reg - oy_reg;
                    end
                    default:
                    begin
                        pt_x_next = xc_reg;
                        pt_y_next = yc_reg;
                    end
                endcase
                state_next = tor_pkg::ST_PLOT_A;
            end
            tor_pkg::ST_PLOT_A:
            begin
                pok_next = !pt_x_reg[35] && (pt_x_reg[34:22] != 13'd0)
                        && (pt_x_reg[34:22] < {3'd0, eff_w})
                        && !pt_y_reg[35] && (pt_y_reg[34:22] != 13'd0)
                        && (pt_y_reg[34:22] < {3'd0, eff_h});
                xi_next    = pt_x_reg[31:22];
                mul_a      = {7'd0, pt_y_reg[31:22]};
                mul_b      = {7'd0, eff_w};
                state_next = tor_pkg::ST_PLOT_B;
            end
            tor_pkg::ST_PLOT_B:
            begin
                if (pok_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prod_reg[ADDR_W-1:0] + ADDR_W'(xi_reg);
                    mem_wdata = word;
                end
                if (show_reg && pidx_reg != 2'd2)
                begin
                    pidx_next  = pidx_reg + 2'd1;
                    state_next = tor_pkg::ST_PLOT_P;
                end
                else if (k_reg + 11'd1 < n_reg)
                begin
                    k_next     = k_reg + 11'd1;
                    state_next = tor_pkg::ST_K;
                end
                else
                begin
                    state_next = tor_pkg::ST_UPDATE;
                end
            end
            tor_pkg::ST_UPDATE:
            begin
                have_prev_next = have_point_reg;
                if (have_point_reg)
                begin
                    early_x_next = last_x_reg;
                    early_y_next = last_y_reg;
                end
                last_x_next     = px_reg;
                last_y_next     = py_reg;
                last_rad_next   = rad_reg;
                last_col_next   = col_reg;
                last_nx_next    = nx_reg;
                last_ny_next    = ny_reg;
                have_point_next = 1'b1;
                state_next      = tor_pkg::ST_FINISH;
            end
            tor_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_pix_next   = pix_reg;
                    state_next     = tor_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tor_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall   = (state_reg != tor_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign pixel_rgba = out_pix_reg;
    assign done_res   = 1'b1;

`ifndef NO_ASSERTIONS
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == tor_pkg::ST_FINISH))
        else $error("result raised outside finish state");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> state_reg == tor_pkg::ST_DISPATCH)
        else $error("accepted transaction not dispatched");

    a_ds_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        ds_resp.done |-> (state_reg == tor_pkg::ST_SQ_WAIT || state_reg == tor_pkg::ST_UX_WAIT
            || state_reg == tor_pkg::ST_UY_WAIT || state_reg == tor_pkg::ST_L_WAIT))
        else $error("root result arrived with nobody waiting");

    a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> 32'(mem_waddr) < DEPTH)
        else $error("store write beyond depth");
`endif

endmodule

// ----- tb/tor_checker.sv -----
// Checker for the tube outline rasterizer: predicts every result from the channels and compares.
module tor_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [8:0]         pos_x,
    input  logic [8:0]         pos_y,
    input  logic [15:0]        radius,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic signed [15:0] normal_x,
    input  logic signed [15:0] normal_y,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [31:0]        pixel_rgba,
    input  logic               done_res,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [9:0]         cfg_data,
    output int                 mismatches,
    output int                 pending,
    output int                 checked,
    output int                 segments,
    output int                 lit_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W = 512;
    localparam int STORE_H = 512;
    localparam longint ONE_Q22 = 64'sd1 << 22;

    typedef struct packed {
        logic [31:0] pixel;
        logic        done;
    } tor_result_t;

    tor_result_t expected_results[$];

    logic [31:0] frame[0:STORE_W*STORE_H-1];
    int          width_reg, height_reg;
    logic        show_reg;
    logic        have_pt, have_prev;
    longint      pt_x, pt_y, pt_rad, prior_x, prior_y, pt_nx, pt_ny;
    logic [23:0] pt_colour;

    initial
    begin
        foreach (frame[i]) frame[i] = '0;
        width_reg = 512;
        height_reg = 512;
        show_reg = 1'b1;
        have_pt = 1'b0;
        have_prev = 1'b0;
        pt_x = 0;
        pt_y = 0;
        pt_rad = 0;
        prior_x = 0;
        prior_y = 0;
        pt_nx = 0;
        pt_ny = 0;
        pt_colour = '0;
        mismatches = 0;
        checked = 0;
        segments = 0;
        lit_reads = 0;
    end

    assign pending = expected_results.size();

    function automatic int eff_w();
        return (width_reg > STORE_W) ? STORE_W : width_reg;
    endfunction

    function automatic int eff_h();
        return (height_reg > STORE_H) ? STORE_H : height_reg;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root, bit_q;
        root = 0;
        bit_q = 64'd1 << 62;
        while (bit_q > v) bit_q >>= 2;
        while (bit_q != 0)
        begin
            if (v >= root + bit_q)
            begin
                v -= root + bit_q;
                root = (root >> 1) + bit_q;
            end
            else
                root >>= 1;
            bit_q >>= 2;
        end
        return root;
    endfunction

    // Q1.14 component of a/|v|, truncated toward zero
    function automatic longint unit_part(longint a, longint unsigned n2);
        longint unsigned mag, q;
        if (n2 == 0) return 0;
        mag = (a < 0) ? -a : a;
        q = int_sqrt(((mag * mag) << 28) / n2);
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void put_pixel(longint xq, longint yq, logic [31:0] word);
        longint xi, yi;
        if (xq < ONE_Q22 || yq < ONE_Q22) return;
        xi = xq >>> 22;
        yi = yq >>> 22;
        if (xi >= eff_w() || yi >= eff_h()) return;
        frame[yi * eff_w() + xi] = word;
    endfunction

    function automatic void draw_span(longint px, longint py, longint r1);
        longint dx, dy, a, b, ux, uy, ln, xc, yc, rr, ex, ey;
        longint unsigned d2, s, n, k, rsum;
        logic [31:0] word;
        dx = px - pt_x;
        dy = py - pt_y;
        d2 = dx * dx + dy * dy;
        s = int_sqrt(d2);
        n = (d2 == 0) ? 1 : ((s * s == d2) ? s : s + 1);
        word = {tor_pkg::PIX_ALPHA, pt_colour};
        a = pt_nx;
        b = pt_ny;
        if (a == 0 && b == 0)
        begin
            ex = have_prev ? prior_x : pt_x;
            ey = have_prev ? prior_y : pt_y;
            a = py - ey;
            b = -(px - ex);
        end
        ux = unit_part(a, a * a + b * b);
        uy = unit_part(b, a * a + b * b);
        for (k = 0; k < n; k++)
        begin
            ln = (d2 != 0) ? longint'(int_sqrt(((k * k) << 32) / d2)) : 0;
            xc = (pt_x * 65536 + ln * dx) * 64;
            yc = (pt_y * 65536 + ln * dy) * 64;
            put_pixel(xc, yc, word);
            if (show_reg)
            begin
                rsum = pt_rad * 65536 + ln * (r1 - pt_rad);
                rr = longint'(rsum >> 16);
                put_pixel(xc + rr * ux, yc + rr * uy, word);
                put_pixel(xc - rr * ux, yc - rr * uy, word);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        tor_result_t res, want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == tor_pkg::CFG_WIDTH) width_reg = cfg_data;
                else if (cfg_index == tor_pkg::CFG_HEIGHT) height_reg = cfg_data;
                else if (cfg_index == tor_pkg::CFG_SHOW) show_reg = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                res = '{pixel: 32'd0, done: 1'b1};
                case (tor_pkg::cmd_t'(cmd))
                    tor_pkg::CMD_CLEAR: foreach (frame[i]) frame[i] = '0;
                    tor_pkg::CMD_POINT:
                    begin
                        if (have_pt)
                        begin
                            draw_span(pos_x, pos_y, radius);
                            segments++;
                            prior_x = pt_x;
                            prior_y = pt_y;
                        end
                        have_prev = have_pt;
                        pt_x = pos_x;
                        pt_y = pos_y;
                        pt_rad = radius;
                        pt_colour = {blue, green, red};
                        pt_nx = normal_x;
                        pt_ny = normal_y;
                        have_pt = 1'b1;
                    end
                    tor_pkg::CMD_END:
                    begin
                        have_pt = 1'b0;
                        have_prev = 1'b0;
                    end
                    default:
                    begin
                        if (pos_x < eff_w() && pos_y < eff_h())
                            res.pixel = frame[pos_y * eff_w() + pos_x];
                        if (res.pixel != 0) lit_reads++;
                    end
                endcase
                expected_results.push_back(res);
            end
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with none expected: pixel %h done %b",
                                 $realtime, pixel_rgba, done_res);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pixel_rgba !== want.pixel || done_res !== want.done)
                    begin
                        if (mismatches < 10)
                            $display("%0t: mismatch pixel exp %h got %h, done exp %b got %b",
                                     $realtime, want.pixel, pixel_rgba, want.done, done_res);
                        mismatches++;
                    end
                end
            end
        end
    end
endmodule

// ----- tb/tb_tube_outline_rasterizer_core.sv -----
// Top testbench for the tube outline rasterizer: stimulus, handshakes and verdict.
module tb_tube_outline_rasterizer_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = tor_pkg::CMD_END;
    logic [8:0]         pos_x = '0;
    logic [8:0]         pos_y = '0;
    logic [15:0]        radius = '0;
    logic [7:0]         red = '0;
    logic [7:0]         green = '0;
    logic [7:0]         blue = '0;
    logic signed [15:0] normal_x = '0;
    logic signed [15:0] normal_y = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        pixel_rgba;
    logic               done_res;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = tor_pkg::CFG_WIDTH;
    logic [9:0]         cfg_data = '0;

    int   mismatches, pending, checked, segments, lit_reads;
    logic no_gaps = 1'b0;
    logic hold_req = 1'b0;
    int   cur_x = 100, cur_y = 100, area_w = 512, area_h = 512;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tube_outline_rasterizer_core DUT (.*);

    tor_checker u_checker (.*);

    // result side: random stall per transaction, one long hold-off on request
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                gap = hold_req ? 400 : (no_gaps ? 0 : $urandom_range(0, 7));
                hold_req = 1'b0;
                if (gap > 0)
                begin
                    @(negedge clk) out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic send(tor_pkg::cmd_t c, int x, int y, int rad, logic [23:0] col,
                        logic [15:0] nx, logic [15:0] ny);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        pos_x <= 9'(x);
        pos_y <= 9'(y);
        radius <= 16'(rad);
        {blue, green, red} <= col;
        normal_x <= nx;
        normal_y <= ny;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk) in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(int w, int h, logic show);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= tor_pkg::CFG_WIDTH;
        cfg_data <= 10'(w);
        @(negedge clk);
        cfg_index <= tor_pkg::CFG_HEIGHT;
        cfg_data <= 10'(h);
        @(negedge clk);
        cfg_index <= tor_pkg::CFG_SHOW;
        cfg_data <= {9'($urandom), show};
        @(negedge clk) cfg_we <= 1'b0;
        area_w = (w > 512) ? 512 : ((w < 1) ? 1 : w);
        area_h = (h > 512) ? 512 : ((h < 1) ? 1 : h);
        cur_x = $urandom_range(0, area_w);
        cur_y = $urandom_range(0, area_h);
    endtask

    function automatic int clamp9(int v);
        return (v < 0) ? 0 : ((v > 511) ? 511 : v);
    endfunction

    task automatic random_items(int count);
        int sel, rad;
        logic [15:0] nx, ny;
        repeat (count)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send(tor_pkg::CMD_END, $urandom, $urandom, $urandom, 24'($urandom),
                     16'($urandom), 16'($urandom));
            else if (sel < 33)
                send(tor_pkg::CMD_READ, clamp9(cur_x + $urandom_range(0, 8) - 4),
                     clamp9(cur_y + $urandom_range(0, 8) - 4),
                     $urandom, 24'($urandom), 16'($urandom), 16'($urandom));
            else
            begin
                if (sel == 99)
                begin
                    cur_x = $urandom_range(0, 511);
                    cur_y = $urandom_range(0, 511);
                end
                else
                begin
                    cur_x = clamp9(cur_x + $urandom_range(0, 12) - 6);
                    cur_y = clamp9(cur_y + $urandom_range(0, 12) - 6);
                end
                rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, 2047);
                nx = 16'($urandom);
                ny = 16'($urandom);
                if ($urandom_range(0, 1) == 0)
                begin
                    nx = '0;
                    ny = '0;
                end
                send(tor_pkg::CMD_POINT, cur_x, cur_y, rad, 24'($urandom), nx, ny);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // directed: extremes, every command, normal sources, bounds
        send(tor_pkg::CMD_READ, 0, 0, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_POINT, 10, 10, 16'h0300, 24'h0000ff, 16'h0, 16'h0);
        send(tor_pkg::CMD_POINT, 20, 10, 16'h0500, 24'h00ff00, 16'h4000, 16'h0);
        send(tor_pkg::CMD_POINT, 20, 10, 16'h0400, 24'hff0000, 16'h0, 16'h0);
        send(tor_pkg::CMD_POINT, 25, 18, 16'h0200, 24'h123456, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 15, 10, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 15, 13, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 15, 7, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_POINT, 0, 0, 16'h0100, 24'hffffff, 16'hc000, 16'h4000);
        send(tor_pkg::CMD_READ, 20, 10, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_END, 0, 0, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_POINT, 511, 511, 16'hffff, 24'hffffff, 16'h8000, 16'h7fff);
        send(tor_pkg::CMD_POINT, 0, 0, 16'h0000, 24'h000000, 16'hffff, 16'h0001);
        send(tor_pkg::CMD_POINT, 3, 500, 16'h0a00, 24'h5a5aa5, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 511, 511, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 1, 1, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 256, 256, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 0, 0, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_END, 0, 0, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_CLEAR, 0, 0, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 256, 256, 0, 24'h0, 16'h0, 16'h0);
        send(tor_pkg::CMD_READ, 15, 10, 0, 24'h0, 16'h0, 16'h0);

        // sender pauses here until every result is in
        drain();
        random_items(60);

        // long receiver hold-off while reads keep coming
        hold_req = 1'b1;
        no_gaps = 1'b1;
        repeat (8) send(tor_pkg::CMD_READ, $urandom, $urandom, 0, 24'h0, 16'h0, 16'h0);
        no_gaps = 1'b0;
        drain();

        set_regs(1023, 1023, 1'b0);
        random_items(55);
        drain();
        set_regs(0, 100, 1'b1);
        random_items(45);
        drain();
        set_regs(60, 1, 1'b1);
        no_gaps = 1'b1;
        random_items(45);
        no_gaps = 1'b0;
        drain();
        set_regs(1, 1, 1'b0);
        random_items(30);
        drain();
        set_regs(40, 30, 1'b1);
        random_items(60);
        drain();
        set_regs(512, 200, 1'b1);
        random_items(50);
        drain();

        $display("Checked %0d results: %0d segments drawn, %0d reads of lit pixels,",
                 checked, segments, lit_reads);
        $display("across seven register settings including zero and oversized sizes.");
        if (mismatches == 0 && pending == 0)
            $display("tb_tube_outline_rasterizer_core: PASS");
        else
            $display("tb_tube_outline_rasterizer_core: FAIL");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", pending);
        $display("tb_tube_outline_rasterizer_core: FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/core/tor_pkg.sv
rtl/core/tor_divsqrt.sv
rtl/core/tube_outline_rasterizer_core.sv
tb/tor_checker.sv
tb/tb_tube_outline_rasterizer_core.sv
